[sv/tdp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the trial-division prime tester.
// No dependencies; imported by the controller, the datapath and the top level.
package tdp_pkg;

    // Default value width and the first trial divisor
    localparam int VALUE_WIDTH_DEF = 31;
    localparam int FIRST_DIVISOR   = 2;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_CHECK,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;          // capture request, divisor = 2, clear divider
        logic step;          // one restoring-division bit
        logic next_div;      // divisor + 1, clear divider
        logic save_verdict;  // latch the verdict bit
        logic verdict;       // verdict to latch (1 = prime)
        logic emit;          // move verdict into the output register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic too_small;     // value is 0 or 1
        logic step_last;     // last quotient bit is being produced
        logic d_gt_q;        // divisor > quotient, so divisor^2 > value
        logic rem_zero;      // divisor divides the value
        logic out_free;      // output register can take a result
    } t_status;

endpackage

[sv/tdp_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for the trial-division prime tester.
// Depends on tdp_pkg (state, command and status types).
module tdp_ctrl
    import tdp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_START;
            end
            ST_START: begin
                if (i_status.too_small) n_state = ST_DONE;
                else                    n_state = ST_DIV;
            end
            ST_DIV: begin
                if (i_status.step_last) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (i_status.d_gt_q || i_status.rem_zero) n_state = ST_DONE;
                else                                      n_state = ST_DIV;
            end
            ST_DONE: begin
                if (i_status.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = i_valid;
            end
            ST_START: begin
                // 0 and 1 are not prime
                if (i_status.too_small) begin
                    o_cmd.save_verdict = 1'b1;
                    o_cmd.verdict      = 1'b0;
                end
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
            end
            ST_CHECK: begin
                if (i_status.d_gt_q) begin
                    o_cmd.save_verdict = 1'b1;
                    o_cmd.verdict      = 1'b1;
                end else if (i_status.rem_zero) begin
                    o_cmd.save_verdict = 1'b1;
                    o_cmd.verdict      = 1'b0;
                end else begin
                    o_cmd.next_div = 1'b1;
                end
            end
            ST_DONE: begin
                o_cmd.emit = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

[sv/tdp_dpath.sv]
`timescale 1ns / 1ps
// Datapath: value and divisor registers, bit-serial restoring divider,
// verdict bit and output register. Depends on tdp_pkg.
module tdp_dpath
    import tdp_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    input  logic [VALUE_WIDTH-1:0] i_number,
    input  logic                   i_stall,
    output t_status                o_status,
    output logic                   o_valid,
    output logic                   o_prime
);

    // Divisor never exceeds about 2^(W/2) + 1
    localparam int DIV_W  = (VALUE_WIDTH + 1) / 2 + 1;
    localparam int STEP_W = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] r_val;
    logic [DIV_W-1:0]       r_div;
    logic [DIV_W-1:0]       r_rem;
    logic [VALUE_WIDTH-1:0] r_quo;
    logic [STEP_W-1:0]      r_step;
    logic                   r_verdict;
    logic                   r_out_valid;
    logic                   r_out_prime;

    logic [DIV_W:0]         shifted;
    logic [DIV_W:0]         diff;
    logic                   fits;

    // One restoring-division step: shift in next value bit, try subtract
    assign shifted = {r_rem, r_val[r_step]};
    assign diff    = shifted - {1'b0, r_div};
    assign fits    = !diff[DIV_W];

    // Divider and operand registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div  <= DIV_W'(FIRST_DIVISOR);
            r_rem  <= '0;
            r_step <= '0;
        end else if (i_cmd.load) begin
            r_val  <= i_number;
            r_div  <= DIV_W'(FIRST_DIVISOR);
            r_rem  <= '0;
            r_step <= STEP_W'(VALUE_WIDTH - 1);
        end else if (i_cmd.next_div) begin
            r_div  <= r_div + DIV_W'(1);
            r_rem  <= '0;
            r_step <= STEP_W'(VALUE_WIDTH - 1);
        end else if (i_cmd.step) begin
            r_rem  <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
            r_quo  <= {r_quo[VALUE_WIDTH-2:0], fits};
            r_step <= r_step - STEP_W'(1);
        end
    end

    // Verdict bit
    always_ff @(posedge i_clk) begin
        if (i_cmd.save_verdict) r_verdict <= i_cmd.verdict;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) r_out_prime <= r_verdict;
    end

    // Status
    assign o_status.too_small = (r_val[VALUE_WIDTH-1:1] == '0);
    assign o_status.step_last = (r_step == '0);
    assign o_status.d_gt_q    = ({{(VALUE_WIDTH - DIV_W){1'b0}}, r_div} > r_quo);
    assign o_status.rem_zero  = (r_rem == '0);
    assign o_status.out_free  = !r_out_valid || !i_stall;

    assign o_valid = r_out_valid;
    assign o_prime = r_out_prime;

endmodule

[sv/trial_division_prime_test_top.sv]
`timescale 1ns / 1ps
// Top level of the trial-division prime tester: controller plus datapath.
// Depends on tdp_pkg, tdp_ctrl and tdp_dpath.
//
//  channel  | valid   | stall   | payload
//  ---------+---------+---------+------------------------
//  request  | i_valid | o_stall | i_number [VALUE_WIDTH]
//  result   | o_valid | i_stall | o_prime
//
// Each trial divisor takes VALUE_WIDTH bit steps of the shared restoring
// divider plus one check step. A 31-bit prime near 2^31 needs about 46340
// divisors tried. 0 and 1 skip the divider and go straight to the result.
// Reset is synchronous, active low. A new request is taken once the last
// result sits in the output register.
module trial_division_prime_test_top
    import tdp_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [VALUE_WIDTH-1:0] i_number,
    output logic                   o_stall,
    output logic                   o_valid,
    output logic                   o_prime,
    input  logic                   i_stall
);

    t_cmd    cmd;
    t_status status;
    logic    busy;

    tdp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    tdp_dpath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_number   (i_number),
        .i_stall    (i_stall),
        .o_status   (status),
        .o_valid    (o_valid),
        .o_prime    (o_prime)
    );

    assign o_stall = busy;

    // An accepted request keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after accepting a request");

    // A new result never overwrites one still held by a stalled consumer
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> !(o_valid && i_stall))
        else $error("result emitted over a stalled result");

    // Prime is only declared once divisor exceeds quotient
    a_prime_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.save_verdict && cmd.verdict) |-> status.d_gt_q)
        else $error("prime verdict before the square bound was reached");

    // The load, step, next-divisor and emit commands are mutually exclusive
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.step, cmd.next_div, cmd.emit}))
        else $error("conflicting datapath commands");

endmodule
